>>> hw/rtl/track_phi_z_ratio_change_check_top_assert.svh
// Assertion macros for the phi/z ratio change check block.
`ifndef TRACK_PHI_Z_RATIO_CHANGE_CHECK_TOP_ASSERT_SVH
`define TRACK_PHI_Z_RATIO_CHANGE_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define TPZR_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define TPZR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/tpzr_pkg.sv
// Shared constants, codes and tables of the phi/z ratio change check.
package tpzr_pkg;
   localparam int COORD_BITS_DEF      = 24;
   localparam int RATIO_FRAC_BITS_DEF = 16;
   localparam int RATIO_W             = 32;
   localparam int NORM_W              = 30;
   localparam int ANG_W               = 31;
   localparam int CW                  = 34;
   localparam int ZW                  = 33;
   localparam int ANG_ITERS           = 30;
   localparam int CORDIC_PER_STAGE    = 3;
   localparam int DIV_PER_STAGE       = 2;
   localparam int CSR_IDX_W           = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANGE_MIN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANGE_MAX = 1'b1;
   localparam logic [ANG_W-1:0] HALF_PI_Q30 = 31'd1686629713;

   function automatic logic [ZW-1:0] atan_q30(input int i);
      logic [ZW-1:0] one;
      one = ZW'(1);
      case (i)
         0: return ZW'(843314857);
         1: return ZW'(497837829);
         2: return ZW'(263043837);
         3: return ZW'(133525159);
         4: return ZW'(67021687);
         5: return ZW'(33543516);
         6: return ZW'(16775851);
         7: return ZW'(8388437);
         8: return ZW'(4194283);
         9: return ZW'(2097149);
         default: return one << (30 - i);
      endcase
   endfunction
endpackage

>>> hw/rtl/tpzr_front.sv
// Front pipeline: chord differences, exact cross/dot products, magnitudes, normalize.
module tpzr_front #(
   parameter int COORD_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic signed [COORD_BITS-1:0] a_x,
   input  logic signed [COORD_BITS-1:0] a_y,
   input  logic signed [COORD_BITS-1:0] b_x,
   input  logic signed [COORD_BITS-1:0] b_y,
   input  logic signed [COORD_BITS-1:0] b_z,
   input  logic signed [COORD_BITS-1:0] c_x,
   input  logic signed [COORD_BITS-1:0] c_y,
   input  logic signed [COORD_BITS-1:0] c_z,
   input  logic signed [COORD_BITS-1:0] d_x,
   input  logic signed [COORD_BITS-1:0] d_y,
   input  logic signed [COORD_BITS-1:0] d_z,
   output logic out_valid,
   output logic [1:0][tpzr_pkg::NORM_W-1:0] y_out,
   output logic [1:0][tpzr_pkg::NORM_W-1:0] x_out,
   output logic fail,
   output logic [COORD_BITS:0] dzn,
   output logic [COORD_BITS:0] dzd
);
   import tpzr_pkg::*;
   localparam int DW  = COORD_BITS + 1;
   localparam int PW  = 2 * DW;
   localparam int SW  = PW + 1;
   localparam int SHW = $clog2(SW + 1);

   function automatic logic signed [DW-1:0] sx(input logic signed [COORD_BITS-1:0] v);
      return DW'(v);
   endfunction

   function automatic logic [SHW-1:0] shamt(input logic [SW-1:0] v);
      logic [SHW-1:0] s;
      s = '0;
      for (int i = NORM_W; i < SW; i++) begin
         if (v[i]) s = SHW'(i - NORM_W + 1);
      end
      return s;
   endfunction

   logic [5:0] vld_ff;
   logic signed [DW-1:0] df_ff [8];
   logic signed [DW-1:0] dz1a_ff, dz1b_ff;
   logic signed [PW-1:0] pr_ff [8];
   logic [DW-1:0] dz2a_ff, dz2b_ff, dz3a_ff, dz3b_ff, dz4a_ff, dz4b_ff;
   logic [DW-1:0] dz5a_ff, dz5b_ff, dz6a_ff, dz6b_ff;
   logic signed [SW-1:0] sm_ff [4];
   logic [SW-1:0] mg_ff [4];
   logic [SW-1:0] mg5_ff [4];
   logic [SHW-1:0] sh_ff [2];
   logic fail4_ff, fail5_ff, fail6_ff;
   logic [1:0][NORM_W-1:0] y6_ff, x6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         df_ff[0] <= sx(b_x) - sx(a_x);
         df_ff[1] <= sx(b_y) - sx(a_y);
         df_ff[2] <= sx(c_x) - sx(a_x);
         df_ff[3] <= sx(c_y) - sx(a_y);
         df_ff[4] <= sx(c_x) - sx(b_x);
         df_ff[5] <= sx(c_y) - sx(b_y);
         df_ff[6] <= sx(d_x) - sx(b_x);
         df_ff[7] <= sx(d_y) - sx(b_y);
         dz1a_ff  <= sx(d_z) - sx(c_z);
         dz1b_ff  <= sx(c_z) - sx(b_z);

         pr_ff[0] <= df_ff[0] * df_ff[3];
         pr_ff[1] <= df_ff[1] * df_ff[2];
         pr_ff[2] <= df_ff[0] * df_ff[2];
         pr_ff[3] <= df_ff[1] * df_ff[3];
         pr_ff[4] <= df_ff[4] * df_ff[7];
         pr_ff[5] <= df_ff[5] * df_ff[6];
         pr_ff[6] <= df_ff[4] * df_ff[6];
         pr_ff[7] <= df_ff[5] * df_ff[7];
         dz2a_ff  <= dz1a_ff[DW-1] ? DW'(-dz1a_ff) : DW'(dz1a_ff);
         dz2b_ff  <= dz1b_ff[DW-1] ? DW'(-dz1b_ff) : DW'(dz1b_ff);

         sm_ff[0] <= SW'(pr_ff[0]) - SW'(pr_ff[1]);
         sm_ff[1] <= SW'(pr_ff[2]) + SW'(pr_ff[3]);
         sm_ff[2] <= SW'(pr_ff[4]) - SW'(pr_ff[5]);
         sm_ff[3] <= SW'(pr_ff[6]) + SW'(pr_ff[7]);
         dz3a_ff  <= dz2a_ff;
         dz3b_ff  <= dz2b_ff;

         for (int i = 0; i < 4; i++) begin
            mg_ff[i] <= sm_ff[i][SW-1] ? SW'(-sm_ff[i]) : SW'(sm_ff[i]);
         end
         fail4_ff <= (sm_ff[0] == '0) || (sm_ff[2] == '0);
         dz4a_ff  <= dz3a_ff;
         dz4b_ff  <= dz3b_ff;

         for (int l = 0; l < 2; l++) begin
            sh_ff[l] <= shamt(mg_ff[2*l] | mg_ff[2*l+1]);
         end
         for (int i = 0; i < 4; i++) begin
            mg5_ff[i] <= mg_ff[i];
         end
         fail5_ff <= fail4_ff;
         dz5a_ff  <= dz4a_ff;
         dz5b_ff  <= dz4b_ff;

         for (int l = 0; l < 2; l++) begin
            y6_ff[l] <= NORM_W'(mg5_ff[2*l] >> sh_ff[l]);
            x6_ff[l] <= NORM_W'(mg5_ff[2*l+1] >> sh_ff[l]);
         end
         fail6_ff <= fail5_ff;
         dz6a_ff  <= dz5a_ff;
         dz6b_ff  <= dz5b_ff;
      end
   end

   assign out_valid = vld_ff[5];
   assign y_out     = y6_ff;
   assign x_out     = x6_ff;
   assign fail      = fail6_ff;
   assign dzn       = dz6a_ff;
   assign dzd       = dz6b_ff;
endmodule

>>> hw/rtl/tpzr_cordic.sv
// Pipelined CORDIC vectoring for two angles, several iterations per stage.
module tpzr_cordic #(
   parameter int COORD_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [1:0][tpzr_pkg::NORM_W-1:0] y_in,
   input  logic [1:0][tpzr_pkg::NORM_W-1:0] x_in,
   input  logic fail_in,
   input  logic [COORD_BITS:0] dzn_in,
   input  logic [COORD_BITS:0] dzd_in,
   output logic out_valid,
   output logic [1:0][tpzr_pkg::ANG_W-1:0] ang,
   output logic fail_out,
   output logic [COORD_BITS:0] dzn_out,
   output logic [COORD_BITS:0] dzd_out
);
   import tpzr_pkg::*;
   localparam int NST = ANG_ITERS / CORDIC_PER_STAGE;

   logic signed [CW-1:0] cx_ff [NST][2];
   logic signed [CW-1:0] cy_ff [NST][2];
   logic signed [ZW-1:0] cz_ff [NST][2];
   logic signed [CW-1:0] cx_in [NST][2];
   logic signed [CW-1:0] cy_in [NST][2];
   logic signed [ZW-1:0] cz_in [NST][2];
   logic [1:0] yz_ff [NST];
   logic [1:0] xz_ff [NST];
   logic fail_ff [NST];
   logic [COORD_BITS:0] dzn_ff [NST];
   logic [COORD_BITS:0] dzd_ff [NST];
   logic [NST-1:0] vld_ff;

   always_comb begin
      logic signed [CW-1:0] x, y, xs, ys;
      logic signed [ZW-1:0] z;
      logic [ZW-1:0] t;
      int it;
      for (int k = 0; k < NST; k++) begin
         for (int l = 0; l < 2; l++) begin
            if (k == 0) begin
               x = CW'(x_in[l]);
               y = CW'(y_in[l]);
               z = '0;
            end else begin
               x = cx_ff[k-1][l];
               y = cy_ff[k-1][l];
               z = cz_ff[k-1][l];
            end
            for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
               it = k * CORDIC_PER_STAGE + j;
               t  = atan_q30(it);
               xs = x >>> it;
               ys = y >>> it;
               if (y > 0) begin
                  x = x + ys;
                  y = y - xs;
                  z = z + $signed(t);
               end else begin
                  x = x - ys;
                  y = y + xs;
                  z = z - $signed(t);
               end
            end
            cx_in[k][l] = x;
            cy_in[k][l] = y;
            cz_in[k][l] = z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NST; k++) begin
            for (int l = 0; l < 2; l++) begin
               cx_ff[k][l] <= cx_in[k][l];
               cy_ff[k][l] <= cy_in[k][l];
               cz_ff[k][l] <= cz_in[k][l];
            end
            if (k == 0) begin
               yz_ff[k]  <= {y_in[1] == '0, y_in[0] == '0};
               xz_ff[k]  <= {x_in[1] == '0, x_in[0] == '0};
               fail_ff[k] <= fail_in;
               dzn_ff[k] <= dzn_in;
               dzd_ff[k] <= dzd_in;
            end else begin
               yz_ff[k]  <= yz_ff[k-1];
               xz_ff[k]  <= xz_ff[k-1];
               fail_ff[k] <= fail_ff[k-1];
               dzn_ff[k] <= dzn_ff[k-1];
               dzd_ff[k] <= dzd_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      logic signed [ZW-1:0] zc;
      for (int l = 0; l < 2; l++) begin
         zc = cz_ff[NST-1][l];
         if (yz_ff[NST-1][l]) begin
            ang[l] = '0;
         end else if (xz_ff[NST-1][l]) begin
            ang[l] = HALF_PI_Q30;
         end else if (zc < 0) begin
            ang[l] = '0;
         end else if (zc > $signed(ZW'(HALF_PI_Q30))) begin
            ang[l] = HALF_PI_Q30;
         end else begin
            ang[l] = ANG_W'(zc);
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign fail_out  = fail_ff[NST-1];
   assign dzn_out   = dzn_ff[NST-1];
   assign dzd_out   = dzd_ff[NST-1];
endmodule

>>> hw/rtl/tpzr_div.sv
// Pipelined restoring divider giving the saturated fixed-point ratio.
module tpzr_div #(
   parameter int NUM_W           = 56,
   parameter int RATIO_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [NUM_W-1:0] num,
   input  logic [NUM_W-1:0] den,
   input  logic fail_in,
   output logic out_valid,
   output logic [tpzr_pkg::RATIO_W-1:0] ratio,
   output logic fail_out,
   output logic zz_out
);
   import tpzr_pkg::*;
   localparam int NST = RATIO_W / DIV_PER_STAGE;
   localparam int IB  = RATIO_W - RATIO_FRAC_BITS;
   localparam int WW  = NUM_W + IB;
   localparam int RW  = NUM_W + 1;

   logic [NST:0] vld_ff;
   logic [RW-1:0] rem_ff [NST+1];
   logic [RW-1:0] rem_in [NST];
   logic [RATIO_W-1:0] low_ff [NST+1];
   logic [RATIO_W-1:0] low_in [NST];
   logic [RATIO_W-1:0] q_ff [NST+1];
   logic [RATIO_W-1:0] q_in [NST];
   logic [NUM_W-1:0] den_ff [NST+1];
   logic sat_ff [NST+1];
   logic zz_ff [NST+1];
   logic fail_ff [NST+1];

   always_comb begin
      logic [RW-1:0] r;
      logic [RATIO_W-1:0] lo, q;
      for (int k = 0; k < NST; k++) begin
         r  = rem_ff[k];
         lo = low_ff[k];
         q  = q_ff[k];
         for (int j = 0; j < DIV_PER_STAGE; j++) begin
            r  = {r[RW-2:0], lo[RATIO_W-1]};
            lo = {lo[RATIO_W-2:0], 1'b0};
            if (r >= RW'(den_ff[k])) begin
               r = r - RW'(den_ff[k]);
               q = {q[RATIO_W-2:0], 1'b1};
            end else begin
               q = {q[RATIO_W-2:0], 1'b0};
            end
         end
         rem_in[k] = r;
         low_in[k] = lo;
         q_in[k]   = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= RW'(num >> IB);
         low_ff[0]  <= {num[IB-1:0], {RATIO_FRAC_BITS{1'b0}}};
         q_ff[0]    <= '0;
         den_ff[0]  <= den;
         sat_ff[0]  <= WW'(num) >= (WW'(den) << IB);
         zz_ff[0]   <= (num == '0) && (den == '0);
         fail_ff[0] <= fail_in;
         for (int k = 0; k < NST; k++) begin
            rem_ff[k+1]  <= rem_in[k];
            low_ff[k+1]  <= low_in[k];
            q_ff[k+1]    <= q_in[k];
            den_ff[k+1]  <= den_ff[k];
            sat_ff[k+1]  <= sat_ff[k];
            zz_ff[k+1]   <= zz_ff[k];
            fail_ff[k+1] <= fail_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[NST];
   assign ratio     = sat_ff[NST] ? '1 : q_ff[NST];
   assign fail_out  = fail_ff[NST];
   assign zz_out    = zz_ff[NST];
endmodule

>>> hw/rtl/track_phi_z_ratio_change_check_top.sv
// Top level of the four-hit phi/z ratio change check.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_a_x .. req_d_z
//   rsp      out  rsp_valid/rsp_stall   rsp_compatible, rsp_ratio_value, rsp_circle_failed
//   csr      in   csr_wr_en             csr_index, csr_wdata
//
// One beat per cycle in, one result per cycle out while no stalled result holds the pipeline;
// the path runs through the front, CORDIC, multiply, divide and output register stages.
// Reset is synchronous, clears all valid bits and sets the window to min 0, max all ones.
// A stalled result freezes the whole pipeline; req_stall follows it.
`include "track_phi_z_ratio_change_check_top_assert.svh"
module track_phi_z_ratio_change_check_top #(
   parameter int COORD_BITS      = tpzr_pkg::COORD_BITS_DEF,
   parameter int RATIO_FRAC_BITS = tpzr_pkg::RATIO_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic signed [COORD_BITS-1:0] req_b_z,
   input  logic signed [COORD_BITS-1:0] req_c_x,
   input  logic signed [COORD_BITS-1:0] req_c_y,
   input  logic signed [COORD_BITS-1:0] req_c_z,
   input  logic signed [COORD_BITS-1:0] req_d_x,
   input  logic signed [COORD_BITS-1:0] req_d_y,
   input  logic signed [COORD_BITS-1:0] req_d_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_compatible,
   output logic [tpzr_pkg::RATIO_W-1:0] rsp_ratio_value,
   output logic rsp_circle_failed,
   input  logic csr_wr_en,
   input  logic [tpzr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpzr_pkg::RATIO_W-1:0] csr_wdata
);
   import tpzr_pkg::*;
   localparam int DW    = COORD_BITS + 1;
   localparam int NUM_W = ANG_W + DW;
   localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;

   logic en;
   logic [RATIO_W-1:0] change_min_ff, change_max_ff;
   logic fr_valid, fr_fail;
   logic [1:0][NORM_W-1:0] fr_y, fr_x;
   logic [DW-1:0] fr_dzn, fr_dzd;
   logic co_valid, co_fail;
   logic [1:0][ANG_W-1:0] co_ang;
   logic [DW-1:0] co_dzn, co_dzd;
   logic mu_valid_ff, mu_fail_ff;
   logic [NUM_W-1:0] num_ff, den_ff;
   logic dv_valid, dv_fail, dv_zz;
   logic [RATIO_W-1:0] dv_ratio;
   logic rsp_valid_ff, rsp_compatible_ff, rsp_circle_failed_ff;
   logic [RATIO_W-1:0] rsp_ratio_value_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         change_min_ff <= '0;
         change_max_ff <= '1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CHANGE_MIN: change_min_ff <= csr_wdata;
            CSR_CHANGE_MAX: change_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   tpzr_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .a_x(req_a_x), .a_y(req_a_y), .b_x(req_b_x), .b_y(req_b_y), .b_z(req_b_z),
      .c_x(req_c_x), .c_y(req_c_y), .c_z(req_c_z),
      .d_x(req_d_x), .d_y(req_d_y), .d_z(req_d_z),
      .out_valid(fr_valid), .y_out(fr_y), .x_out(fr_x), .fail(fr_fail),
      .dzn(fr_dzn), .dzd(fr_dzd)
   );

   tpzr_cordic #(.COORD_BITS(COORD_BITS)) u_cordic (
      .clock(clock), .reset(reset), .en(en), .in_valid(fr_valid),
      .y_in(fr_y), .x_in(fr_x), .fail_in(fr_fail), .dzn_in(fr_dzn), .dzd_in(fr_dzd),
      .out_valid(co_valid), .ang(co_ang), .fail_out(co_fail),
      .dzn_out(co_dzn), .dzd_out(co_dzd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_valid_ff <= 1'b0;
      end else if (en) begin
         mu_valid_ff <= co_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff     <= NUM_W'(co_ang[0]) * NUM_W'(co_dzn);
         den_ff     <= NUM_W'(co_ang[1]) * NUM_W'(co_dzd);
         mu_fail_ff <= co_fail;
      end
   end

   tpzr_div #(.NUM_W(NUM_W), .RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .en(en), .in_valid(mu_valid_ff),
      .num(num_ff), .den(den_ff), .fail_in(mu_fail_ff),
      .out_valid(dv_valid), .ratio(dv_ratio), .fail_out(dv_fail), .zz_out(dv_zz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_circle_failed_ff <= dv_fail;
         if (dv_fail || dv_zz) begin
            rsp_compatible_ff  <= 1'b1;
            rsp_ratio_value_ff <= RATIO_ONE;
         end else begin
            rsp_compatible_ff  <= (dv_ratio >= change_min_ff) && (dv_ratio <= change_max_ff);
            rsp_ratio_value_ff <= dv_ratio;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_compatible    = rsp_compatible_ff;
   assign rsp_ratio_value   = rsp_ratio_value_ff;
   assign rsp_circle_failed = rsp_circle_failed_ff;

   `TPZR_ASSERT_IMPLIES(a_fail_forces_one, clock, reset, rsp_valid_ff && rsp_circle_failed_ff, rsp_compatible_ff && rsp_ratio_value_ff == RATIO_ONE)
   `TPZR_ASSERT_IMPLIES(a_reject_outside, clock, reset, rsp_valid_ff && !rsp_compatible_ff, rsp_ratio_value_ff < change_min_ff || rsp_ratio_value_ff > change_max_ff)
   `TPZR_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid_ff && !mu_valid_ff)
endmodule

>>> verif/tb.sv
// Self-checking testbench for the four-hit phi/z ratio change check.
`timescale 1ns / 1ps
module tb;
   import tpzr_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int FB = RATIO_FRAC_BITS_DEF;
   localparam int LATENCY = 35;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct {
      logic signed [CB-1:0] ax, ay, bx, by, bz, cx, cy, cz, dx, dy, dz;
   } hits_type;

   typedef struct {
      logic        compatible;
      logic [31:0] ratio;
      logic        failed;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CB-1:0] req_a_x = '0, req_a_y = '0, req_b_x = '0, req_b_y = '0;
   logic signed [CB-1:0] req_b_z = '0, req_c_x = '0, req_c_y = '0, req_c_z = '0;
   logic signed [CB-1:0] req_d_x = '0, req_d_y = '0, req_d_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_compatible;
   logic [RATIO_W-1:0] rsp_ratio_value;
   logic rsp_circle_failed;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CHANGE_MIN;
   logic [RATIO_W-1:0] csr_wdata = '0;
   logic req_taken = 1'b0;

   track_phi_z_ratio_change_check_top u_top (.*);

   always #10 clock = ~clock;

   hits_type pending_hits[$];
   verdict_type expected_verdicts[$];
   logic [31:0] win_min, win_max;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int hold_off_cycles = 0;
   int errors = 0;
   longint cycle_count = 0;

   function automatic logic [127:0] abs_sum(longint p1, longint q1, longint p2, longint q2,
                                            bit sub);
      logic signed [127:0] s;
      s = 128'(p1) * 128'(q1);
      if (sub) s = s - 128'(p2) * 128'(q2);
      else s = s + 128'(p2) * 128'(q2);
      return s < 0 ? -s : s;
   endfunction

   function automatic longint turn_angle(logic [127:0] yw, logic [127:0] xw);
      longint x, y, z, t, xs, ys;
      z = 0;
      while (yw >= (128'd1 << 30) || xw >= (128'd1 << 30)) begin
         yw = yw >> 1;
         xw = xw >> 1;
      end
      y = longint'(yw);
      x = longint'(xw);
      if (y == 0) return 0;
      if (x == 0) return HALF_PI_Q30;
      for (int i = 0; i < ANG_ITERS; i++) begin
         case (i)
            0: t = 843314857;
            1: t = 497837829;
            2: t = 263043837;
            3: t = 133525159;
            4: t = 67021687;
            5: t = 33543516;
            6: t = 16775851;
            7: t = 8388437;
            8: t = 4194283;
            9: t = 2097149;
            default: t = longint'(1) << (30 - i);
         endcase
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += t;
         end else begin
            x -= ys; y += xs; z -= t;
         end
      end
      if (z < 0) z = 0;
      if (z > HALF_PI_Q30) z = HALF_PI_Q30;
      return z;
   endfunction

   function automatic verdict_type judge_hits(hits_type h);
      verdict_type v;
      longint u1x, u1y, v1x, v1y, u2x, u2y, v2x, v2y, dzc, dcb;
      logic [127:0] cr1, cr2, num, den, q;
      u1x = h.bx - h.ax; u1y = h.by - h.ay; v1x = h.cx - h.ax; v1y = h.cy - h.ay;
      u2x = h.cx - h.bx; u2y = h.cy - h.by; v2x = h.dx - h.bx; v2y = h.dy - h.by;
      cr1 = abs_sum(u1x, v1y, u1y, v1x, 1'b1);
      cr2 = abs_sum(u2x, v2y, u2y, v2x, 1'b1);
      v.failed = 1'b0;
      if (cr1 == 0 || cr2 == 0) begin
         v.compatible = 1'b1; v.ratio = 32'(1) << FB; v.failed = 1'b1;
         return v;
      end
      dzc = h.dz - h.cz; if (dzc < 0) dzc = -dzc;
      dcb = h.cz - h.bz; if (dcb < 0) dcb = -dcb;
      num = 128'(turn_angle(cr1, abs_sum(u1x, v1x, u1y, v1y, 1'b0))) * 128'(dzc);
      den = 128'(turn_angle(cr2, abs_sum(u2x, v2x, u2y, v2y, 1'b0))) * 128'(dcb);
      if (den == 0) begin
         if (num == 0) begin
            v.compatible = 1'b1; v.ratio = 32'(1) << FB;
            return v;
         end
         v.ratio = 32'hFFFF_FFFF;
      end else begin
         q = (num << FB) / den;
         v.ratio = (q >> 32) != 0 ? 32'hFFFF_FFFF : q[31:0];
      end
      v.compatible = v.ratio >= win_min && v.ratio <= win_max;
      return v;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_hits.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               hits_type h;
               h = pending_hits.pop_front();
               expected_verdicts.push_back(judge_hits(h));
               req_a_x <= h.ax; req_a_y <= h.ay; req_b_x <= h.bx; req_b_y <= h.by;
               req_b_z <= h.bz; req_c_x <= h.cx; req_c_y <= h.cy; req_c_z <= h.cz;
               req_d_x <= h.dx; req_d_y <= h.dy; req_d_z <= h.dz;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= $urandom_range(99) < recv_idle_pct;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_valid && !req_stall;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[track_phi_z_ratio_change_check_top] ERROR");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected result beat");
            errors++;
         end else begin
            verdict_type e;
            e = expected_verdicts.pop_front();
            if (rsp_compatible !== e.compatible) begin
               $error("compatible exp %0d got %0d", e.compatible, rsp_compatible);
               errors++;
            end
            if (rsp_ratio_value !== e.ratio) begin
               $error("ratio_value exp %0h got %0h", e.ratio, rsp_ratio_value);
               errors++;
            end
            if (rsp_circle_failed !== e.failed) begin
               $error("circle_failed exp %0d got %0d", e.failed, rsp_circle_failed);
               errors++;
            end
         end
      end
   end

   function automatic logic signed [CB-1:0] rand_coord(int span);
      case ($urandom_range(9))
         0: return {1'b1, {(CB-1){1'b0}}};
         1: return {1'b0, {(CB-1){1'b1}}};
         2, 3: return CB'($urandom);
         default: return CB'($signed($urandom_range(2 * span)) - span);
      endcase
   endfunction

   function automatic hits_type rand_hits();
      hits_type h;
      int span;
      span = ($urandom_range(3) == 0) ? 8000000 : 20000;
      h.ax = rand_coord(span); h.ay = rand_coord(span);
      h.bx = rand_coord(span); h.by = rand_coord(span); h.bz = rand_coord(span);
      h.cx = rand_coord(span); h.cy = rand_coord(span); h.cz = rand_coord(span);
      h.dx = rand_coord(span); h.dy = rand_coord(span); h.dz = rand_coord(span);
      case ($urandom_range(11))
         0: begin h.cx = h.bx; h.cy = h.by; end
         1: begin h.dx = 2 * h.cx - h.bx; h.dy = 2 * h.cy - h.by; end
         2: h.bz = h.cz;
         3: begin h.bz = h.cz; h.dz = h.cz; end
         4: h.dz = h.cz + CB'($urandom_range(3));
         default: ;
      endcase
      return h;
   endfunction

   function automatic hits_type make_hits(int ax, int ay, int bx, int by, int bz, int cx,
                                          int cy, int cz, int dx, int dy, int dz);
      hits_type h;
      h.ax = ax; h.ay = ay; h.bx = bx; h.by = by; h.bz = bz; h.cx = cx; h.cy = cy;
      h.cz = cz; h.dx = dx; h.dy = dy; h.dz = dz;
      return h;
   endfunction

   task automatic write_window(logic [31:0] lo, logic [31:0] hi);
      repeat (LATENCY + 5) @(negedge clock);
      csr_wr_en <= 1'b1; csr_index <= CSR_CHANGE_MIN; csr_wdata <= lo;
      @(negedge clock);
      csr_index <= CSR_CHANGE_MAX; csr_wdata <= hi;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      win_min = lo;
      win_max = hi;
   endtask

   task automatic drain();
      while (pending_hits.size() > 0 || expected_verdicts.size() > 0) @(negedge clock);
   endtask

   task automatic run_random(int n);
      repeat (n) pending_hits.push_back(rand_hits());
      drain();
   endtask

   initial begin
      int mx, mn;
      mx = 8388607;
      mn = -8388608;
      win_min = 0;
      win_max = 32'hFFFF_FFFF;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      pending_hits.push_back(make_hits(0, 0, 1000, 0, 0, 2000, 0, 100, 3000, 0, 200));
      pending_hits.push_back(make_hits(0, 0, 5, 5, 0, 5, 5, 10, 9, 1, 20));
      pending_hits.push_back(make_hits(0, 0, 1000, 100, 0, 2000, 400, 100, 3000, 900, 300));
      pending_hits.push_back(make_hits(0, 0, 1000, 100, 50, 2000, 400, 50, 3000, 900, 300));
      pending_hits.push_back(make_hits(0, 0, 1000, 100, 50, 2000, 400, 50, 3000, 900, 50));
      pending_hits.push_back(make_hits(0, 0, 1000, 100, 0, 2000, 400, 100, 3000, 900, 100));
      pending_hits.push_back(make_hits(0, 0, 1000, 0, 0, 1000, 1000, 1, 0, 1000, mx));
      pending_hits.push_back(make_hits(0, 0, 1000000, 1, 0, 2000000, 3, 1, 3000000, 6, 2));
      pending_hits.push_back(make_hits(mn, mn, mx, mn, mn, mx, mx, 0, mn, mx, mx));
      pending_hits.push_back(make_hits(mx, mx, mn, mx, mx, mn, mn, mn, mx, mn, mn));
      pending_hits.push_back(make_hits(mn, 0, 0, mx, 1, mx, 0, 0, 0, mn, mx));
      pending_hits.push_back(make_hits(-1, -1, -1, -1, -1, 0, 0, 0, 1, 1, 1));
      pending_hits.push_back(make_hits(0, 0, 10, 0, 0, 10, 10, mx, 0, 10, mn));
      drain();

      send_idle_pct = 17; recv_idle_pct = 72;
      run_random(300);
      write_window(32'h0000_8000, 32'h0002_0000);
      run_random(250);
      write_window(32'hFFFF_FFFF, 32'h0000_0000);
      send_idle_pct = 72; recv_idle_pct = 17;
      run_random(200);
      write_window(32'h0000_0000, 32'h0000_0000);
      hold_off_cycles = 120;
      run_random(200);
      write_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_idle_pct = 0; recv_idle_pct = 0;
      run_random(200);
      write_window(32'h0001_0000, 32'h0001_0000);
      run_random(200);

      repeat (LATENCY + 10) @(negedge clock);
      if (errors == 0 && expected_verdicts.size() == 0)
         $display("[track_phi_z_ratio_change_check_top] OK");
      else
         $display("[track_phi_z_ratio_change_check_top] ERROR");
      $finish;
   end
endmodule
